@@ rtl/sspg_pkg.sv @@
// shared types and constants for the step pulse generator
`default_nettype none

package sspg_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CFG_ADDR_W = 4;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 104;

   localparam logic [26:0] TICK_HZ_RESET = 27'd48000000;
   localparam logic [19:0] MIN_RATE_RESET = 20'd1;
   localparam logic [15:0] PULSE_TICKS_RESET = 16'd0;
   localparam logic [DATA_W-1:0] PERIOD_RESET = 32'd2880000000;

   localparam logic [DATA_W-1:0] DECEL_STEP = 32'd400;
   localparam logic [DATA_W-1:0] DECEL_ZONE = 32'd30;
   localparam logic [32:0] SEC_PER_MIN = 33'd60;

   typedef enum logic [2:0] {
      REQ_TICK   = 3'd0,
      REQ_RATE   = 3'd1,
      REQ_DIR    = 3'd2,
      REQ_STEPS  = 3'd3,
      REQ_EXEC   = 3'd4,
      REQ_STOP   = 3'd5,
      REQ_POS    = 3'd6,
      REQ_ENABLE = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_TICK_HZ     = 2'd0,
      CSR_MIN_RATE    = 2'd1,
      CSR_PULSE_TICKS = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ rtl/stepper_step_pulse_generator.sv @@
// step and direction pulse generator top level with sequencer and csr port
// usage:
//   each request on req_ (tuser = request kind, tdata = operands) is one
//   command or one timer tick; each request yields exactly one response on
//   rsp_ carrying the pin levels, position, budget and rate after it.
//   configuration is written through the csr_ port (tick_hz at 0x0,
//   min_rate at 0x4, pulse_ticks at 0x8); the user must write it only
//   while no request is in flight, which the block does not enforce.
//   every request ends with a rate readback tick_hz*60 / period, done on one
//   shared divider; a set rate or an end-of-move restore adds one division,
//   a decelerating step adds two.
//   req_tready is high only while the sequencer is idle, one request at a
//   time; a request is never taken while another is in process.
//   a response waits in its output register while rsp_tready is low; the
//   next request is still taken, and its response waits for the first.
//   reset is synchronous; it returns the csr registers and motion state to
//   their defaults with the driver disabled and the period counter stopped.
`default_nettype none

module stepper_step_pulse_generator (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // rate_value, steps_value, position_value, forward, enable, zero pad
   input  wire  [sspg_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire  [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // step_pin, dir_pin, disable_pin, position_now, steps_left, rate_now,
   // timer_running, moving_mode, zero pad
   output logic [sspg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [sspg_pkg::CFG_ADDR_W-1:0] csr_paddr,
   input  wire  [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import sspg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_DIV    = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      OP_SET_RATE,
      OP_RESTORE,
      OP_DECEL_CUR,
      OP_DECEL_SET,
      OP_EXEC_CUR,
      OP_OUT
   } op_type;

   function automatic logic [DATA_W-1:0] rate_fix(input logic [DATA_W-1:0] r);
      rate_fix = (r == '0) ? DATA_W'(1) : r;
   endfunction

   // configuration
   logic [26:0] tick_hz_ff;
   logic [19:0] min_rate_ff;
   logic [15:0] pulse_ticks_ff;
   logic        csr_write;
   csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_hz_ff <= TICK_HZ_RESET;
         min_rate_ff <= MIN_RATE_RESET;
         pulse_ticks_ff <= PULSE_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_TICK_HZ:     tick_hz_ff <= csr_pwdata[26:0];
            CSR_MIN_RATE:    min_rate_ff <= csr_pwdata[19:0];
            CSR_PULSE_TICKS: pulse_ticks_ff <= csr_pwdata[15:0];
            CSR_UNUSED:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_TICK_HZ:     csr_prdata = {5'd0, tick_hz_ff};
         CSR_MIN_RATE:    csr_prdata = {12'd0, min_rate_ff};
         CSR_PULSE_TICKS: csr_prdata = {16'd0, pulse_ticks_ff};
         CSR_UNUSED:      csr_prdata = '0;
      endcase
   end

   // ticks per minute, saturated
   logic [32:0]       tpm_full;
   logic [DATA_W-1:0] tpm;

   assign tpm_full = 33'(tick_hz_ff) * SEC_PER_MIN;
   assign tpm = tpm_full[32] ? '1 : tpm_full[DATA_W-1:0];

   // shared divider
   logic              div_start;
   logic [DATA_W-1:0] div_divisor;
   logic [DATA_W-1:0] div_quo;
   div_status_type    div_stat;

   sspg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tpm),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_stat)
   );

   // sequencer and motion state
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   req_kind_type      kind_ff, kind_in;
   logic [DATA_W-1:0] rate_val_ff, rate_val_in;
   logic [DATA_W-1:0] steps_val_ff, steps_val_in;
   logic [DATA_W-1:0] pos_val_ff, pos_val_in;
   logic              fwd_ff, fwd_in;
   logic              en_ff, en_in;

   logic [DATA_W-1:0] period_count_ff, period_count_in;
   logic [DATA_W-1:0] active_period_ff, active_period_in;
   logic [DATA_W-1:0] pending_period_ff, pending_period_in;
   logic [DATA_W-1:0] saved_rate_ff, saved_rate_in;
   logic [DATA_W-1:0] step_budget_ff, step_budget_in;
   logic [DATA_W-1:0] position_ff, position_in;
   logic [15:0]       pulse_count_ff, pulse_count_in;
   logic              dir_ff, dir_in;
   logic              step_ff, step_in;
   logic              disable_ff, disable_in;
   logic              timer_en_ff, timer_en_in;
   logic              exec_mode_ff, exec_mode_in;
   logic [DATA_W-1:0] rate_hold_ff, rate_hold_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] budget_dec;
   logic [DATA_W-1:0] decel_rate;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign budget_dec = step_budget_ff - 1'b1;

   always_comb begin
      decel_rate = (div_quo > DECEL_STEP) ? div_quo - DECEL_STEP : '0;
      if (decel_rate < DATA_W'(min_rate_ff)) begin
         decel_rate = DATA_W'(min_rate_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      kind_in = kind_ff;
      rate_val_in = rate_val_ff;
      steps_val_in = steps_val_ff;
      pos_val_in = pos_val_ff;
      fwd_in = fwd_ff;
      en_in = en_ff;
      period_count_in = period_count_ff;
      active_period_in = active_period_ff;
      pending_period_in = pending_period_ff;
      saved_rate_in = saved_rate_ff;
      step_budget_in = step_budget_ff;
      position_in = position_ff;
      pulse_count_in = pulse_count_ff;
      dir_in = dir_ff;
      step_in = step_ff;
      disable_in = disable_ff;
      timer_en_in = timer_en_ff;
      exec_mode_in = exec_mode_ff;
      rate_hold_in = rate_hold_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_start = 1'b0;
      div_divisor = pending_period_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_kind_type'(req_tuser);
               rate_val_in = req_tdata[31:0];
               steps_val_in = req_tdata[63:32];
               pos_val_in = req_tdata[95:64];
               fwd_in = req_tdata[96];
               en_in = req_tdata[97];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DIV;
            op_in = OP_OUT;
            div_start = 1'b1;
            unique case (kind_ff)
               REQ_TICK: begin
                  if (step_ff) begin
                     if (pulse_count_ff == '0) begin
                        step_in = 1'b0;
                     end else begin
                        pulse_count_in = pulse_count_ff - 1'b1;
                     end
                  end
                  if (timer_en_ff) begin
                     if (period_count_ff <= DATA_W'(1)) begin
                        period_count_in = active_period_ff;
                        step_in = 1'b1;
                        pulse_count_in = pulse_ticks_ff;
                        position_in = dir_ff ? position_ff + 1'b1 : position_ff - 1'b1;
                        if (!step_budget_ff[DATA_W-1] && budget_dec == '0) begin
                           // end of move: restore the saved rate
                           op_in = OP_RESTORE;
                           div_divisor = rate_fix(saved_rate_ff);
                           exec_mode_in = 1'b0;
                           step_budget_in = '1;
                           timer_en_in = 1'b0;
                        end else if (!step_budget_ff[DATA_W-1]
                                     && (budget_dec[DATA_W-1] || budget_dec < DECEL_ZONE)) begin
                           op_in = OP_DECEL_CUR;
                           step_budget_in = budget_dec;
                        end else begin
                           if (!step_budget_ff[DATA_W-1]) begin
                              step_budget_in = budget_dec;
                           end
                           if (!exec_mode_ff) begin
                              timer_en_in = 1'b0;
                           end else begin
                              active_period_in = pending_period_ff;
                              period_count_in = pending_period_ff;
                              timer_en_in = 1'b1;
                           end
                        end
                     end else begin
                        period_count_in = period_count_ff - 1'b1;
                     end
                  end
               end
               REQ_RATE: begin
                  op_in = OP_SET_RATE;
                  div_divisor = rate_fix(rate_val_ff);
               end
               REQ_DIR:   dir_in = fwd_ff;
               REQ_STEPS: step_budget_in = steps_val_ff[DATA_W-1] ? '1 : steps_val_ff;
               REQ_EXEC: begin
                  op_in = OP_EXEC_CUR;
                  exec_mode_in = 1'b1;
                  if (!timer_en_ff) begin
                     timer_en_in = 1'b1;
                     period_count_in = active_period_ff;
                  end
               end
               REQ_STOP:   timer_en_in = 1'b0;
               REQ_POS:    position_in = pos_val_ff;
               REQ_ENABLE: disable_in = !en_ff;
            endcase
         end
         S_DIV: begin
            if (div_stat.done) begin
               unique case (op_ff)
                  OP_SET_RATE, OP_RESTORE, OP_DECEL_SET: begin
                     pending_period_in = div_quo;
                     if (div_quo < period_count_ff) begin
                        active_period_in = div_quo;
                        period_count_in = div_quo;
                        if (op_ff != OP_RESTORE) begin
                           timer_en_in = 1'b1;
                        end
                     end
                     if (op_ff == OP_DECEL_SET) begin
                        if (!exec_mode_ff) begin
                           timer_en_in = 1'b0;
                        end else begin
                           active_period_in = div_quo;
                           period_count_in = div_quo;
                           timer_en_in = 1'b1;
                        end
                     end
                     op_in = OP_OUT;
                     div_start = 1'b1;
                     div_divisor = div_quo;
                  end
                  OP_DECEL_CUR: begin
                     op_in = OP_DECEL_SET;
                     div_start = 1'b1;
                     div_divisor = rate_fix(decel_rate);
                  end
                  OP_EXEC_CUR: begin
                     saved_rate_in = div_quo;
                     rate_hold_in = div_quo;
                     state_in = S_FINISH;
                  end
                  OP_OUT: begin
                     rate_hold_in = div_quo;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = {3'd0, exec_mode_ff, timer_en_ff, rate_hold_ff,
                              step_budget_ff, position_ff, disable_ff, dir_ff, step_ff};
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_OUT;
         period_count_ff <= '0;
         active_period_ff <= '0;
         pending_period_ff <= PERIOD_RESET;
         saved_rate_ff <= DATA_W'(MIN_RATE_RESET);
         step_budget_ff <= '1;
         position_ff <= '0;
         pulse_count_ff <= '0;
         dir_ff <= 1'b0;
         step_ff <= 1'b0;
         disable_ff <= 1'b1;
         timer_en_ff <= 1'b0;
         exec_mode_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         period_count_ff <= period_count_in;
         active_period_ff <= active_period_in;
         pending_period_ff <= pending_period_in;
         saved_rate_ff <= saved_rate_in;
         step_budget_ff <= step_budget_in;
         position_ff <= position_in;
         pulse_count_ff <= pulse_count_in;
         dir_ff <= dir_in;
         step_ff <= step_in;
         disable_ff <= disable_in;
         timer_en_ff <= timer_en_in;
         exec_mode_ff <= exec_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      rate_val_ff <= rate_val_in;
      steps_val_ff <= steps_val_in;
      pos_val_ff <= pos_val_in;
      fwd_ff <= fwd_in;
      en_ff <= en_in;
      rate_hold_ff <= rate_hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_DECODE && !req_tready)
      else $error("request accepted without decode");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && !div_stat.busy && !div_stat.done |-> 1'b0)
      else $error("sequencer waits on an idle divider");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("response not loaded");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECODE |=> div_stat.busy)
      else $error("decode did not start the divider");

endmodule

`default_nettype wire

@@ rtl/sspg_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module sspg_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [sspg_pkg::DATA_W-1:0] dividend,
   input  wire  [sspg_pkg::DATA_W-1:0] divisor,
   output logic [sspg_pkg::DATA_W-1:0] quotient,
   output sspg_pkg::div_status_type    status
);
   import sspg_pkg::*;

   localparam int unsigned CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DATA_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W+1]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign status = '{busy: busy_ff, done: done_ff};

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff && !done_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff == '0 |=> done_ff)
      else $error("divider missed its last step");

endmodule

`default_nettype wire
